@@ hw/rtl/msk_pkg.sv @@
// Shared constants, codes and control types of the min-tracking stack.
`default_nettype none

package msk_pkg;

  // Stack capacity and the widths that follow from it.
  localparam int STACK_DEPTH = 64;
  localparam int PTR_W       = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
  localparam int COUNT_W     = $clog2(STACK_DEPTH + 1);
  localparam int VALUE_W     = 32;
  localparam int HELD_W      = 7;

  // Command codes carried by an input item.
  typedef enum logic [1:0] {
    CMD_PUSH = 2'd0,
    CMD_POP  = 2'd1,
    CMD_MIN  = 2'd2,
    CMD_PEEK = 2'd3
  } command_t;

  // Status codes returned with every result item.
  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_t;

  // Controller commands to the datapath.
  typedef struct packed {
    logic accept;    // take the input item and register its result
    logic load_top;  // refill the cached top entry from the RAM read data
  } ctrl_cmd_t;

  // Datapath status to the controller.
  typedef struct packed {
    logic need_reload;  // the presented item is a pop that leaves entries behind
  } dp_status_t;

endpackage

`default_nettype wire

@@ hw/rtl/msk_ram.sv @@
// Generic single-port-write, single-port-read RAM with registered read data.
`default_nettype none

module msk_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64,
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic              clk,
  input  wire logic              we,
  input  wire logic [ADDR_W-1:0] waddr,
  input  wire logic [WIDTH-1:0]  wdata,
  input  wire logic [ADDR_W-1:0] raddr,
  output logic      [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port.
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

@@ hw/rtl/msk_ctrl.sv @@
// Controller of the min-tracking stack: handshakes and the top-entry refill state.
`default_nettype none

module msk_ctrl (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                in_valid,
  output logic                     in_stall,
  output logic                     out_valid,
  input  wire logic                out_stall,
  input  wire msk_pkg::dp_status_t dp_status,
  output msk_pkg::ctrl_cmd_t       cmd
);

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_LOAD = 2'b10
  } state_t;

  state_t state;
  state_t state_next;
  logic   out_valid_next;
  logic   accept;

  // An item is taken when idle and the output register is free or draining.
  assign in_stall = (state != S_IDLE) || (out_valid && out_stall);
  assign accept   = in_valid && !in_stall;

  assign cmd.accept   = accept;
  assign cmd.load_top = (state == S_LOAD);

  // Next state: a pop that leaves entries behind passes through S_LOAD to refill the top.
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (accept && dp_status.need_reload) begin
          state_next = S_LOAD;
        end
      end
      S_LOAD: begin
        state_next = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // Output valid is set by an accepted item and cleared when the result is taken.
  always_comb begin
    out_valid_next = out_valid;
    if (accept) begin
      out_valid_next = 1'b1;
    end else if (!out_stall) begin
      out_valid_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
    end
  end

  // No item is taken while the top entry is being refilled.
  a_no_accept_in_load: assert property (@(posedge clk) disable iff (rst)
    (state == S_LOAD) |-> in_stall)
    else $error("item accepted during top refill");

  // The refill always returns to idle in the following cycle.
  a_load_one_cycle: assert property (@(posedge clk) disable iff (rst)
    (state == S_LOAD) |=> (state == S_IDLE))
    else $error("top refill did not finish in one cycle");

  // A pop that leaves entries behind always triggers a refill.
  a_reload_follows_pop: assert property (@(posedge clk) disable iff (rst)
    (accept && dp_status.need_reload) |=> (state == S_LOAD))
    else $error("missing top refill after pop");

  // A new result only appears after an accepted item.
  a_result_after_accept: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(accept))
    else $error("result valid without an accepted item");

endmodule

`default_nettype wire

@@ hw/rtl/msk_datapath.sv @@
// Datapath of the min-tracking stack: entry RAM, cached top entry, count and result registers.
`default_nettype none

module msk_datapath (
  input  wire logic                                  clk,
  input  wire logic                                  rst,
  input  wire msk_pkg::ctrl_cmd_t                    cmd,
  output msk_pkg::dp_status_t                        dp_status,
  input  wire logic [1:0]                            command,
  input  wire logic signed [msk_pkg::VALUE_W-1:0]    push_value,
  output logic signed [msk_pkg::VALUE_W-1:0]         result_value,
  output logic [1:0]                                 status,
  output logic [msk_pkg::HELD_W-1:0]                 entries_held
);

  localparam int ENTRY_W = 2 * msk_pkg::VALUE_W;

  logic [msk_pkg::COUNT_W-1:0]        count;
  logic [msk_pkg::COUNT_W-1:0]        count_next;
  logic signed [msk_pkg::VALUE_W-1:0] top_value;
  logic signed [msk_pkg::VALUE_W-1:0] top_min;
  logic signed [msk_pkg::VALUE_W-1:0] push_min;
  logic signed [msk_pkg::VALUE_W-1:0] result_next;
  msk_pkg::status_t                   status_next;
  logic                               is_full;
  logic                               is_empty;
  logic                               ram_we;
  logic [msk_pkg::COUNT_W-1:0]        below_top;
  logic [ENTRY_W-1:0]                 ram_rdata;

  assign is_full  = (count == msk_pkg::COUNT_W'(msk_pkg::STACK_DEPTH));
  assign is_empty = (count == '0);

  // Running minimum of the new entry and everything beneath it.
  assign push_min = (!is_empty && (top_min < push_value)) ? top_min : push_value;

  // Entry under the current top, fetched when a pop exposes it.
  assign below_top = count - msk_pkg::COUNT_W'(2);

  assign dp_status.need_reload = (command == msk_pkg::CMD_POP) &&
                                 (count > msk_pkg::COUNT_W'(1));

  // Per-command result, status and new entry count.
  always_comb begin
    result_next = '0;
    status_next = msk_pkg::ST_OK;
    count_next  = count;
    ram_we      = 1'b0;
    case (command)
      msk_pkg::CMD_PUSH: begin
        if (is_full) begin
          status_next = msk_pkg::ST_FULL;
        end else begin
          ram_we     = cmd.accept;
          count_next = count + msk_pkg::COUNT_W'(1);
        end
      end
      msk_pkg::CMD_POP: begin
        if (is_empty) begin
          status_next = msk_pkg::ST_EMPTY;
        end else begin
          result_next = top_value;
          count_next  = count - msk_pkg::COUNT_W'(1);
        end
      end
      msk_pkg::CMD_MIN: begin
        if (is_empty) begin
          status_next = msk_pkg::ST_EMPTY;
        end else begin
          result_next = top_min;
        end
      end
      msk_pkg::CMD_PEEK: begin
        if (is_empty) begin
          status_next = msk_pkg::ST_EMPTY;
        end else begin
          result_next = top_value;
        end
      end
      default: begin
        status_next = msk_pkg::ST_OK;
      end
    endcase
  end

  // Entry store: each word holds the running minimum above the value.
  msk_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (msk_pkg::STACK_DEPTH)
  ) u_entry_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (count[msk_pkg::PTR_W-1:0]),
    .wdata ({push_min, push_value}),
    .raddr (below_top[msk_pkg::PTR_W-1:0]),
    .rdata (ram_rdata)
  );

  // Entry count.
  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (cmd.accept) begin
      count <= count_next;
    end
  end

  // Cached top entry: set by a push, refilled from the RAM after a pop.
  always_ff @(posedge clk) begin
    if (cmd.load_top) begin
      top_min   <= ram_rdata[ENTRY_W-1:msk_pkg::VALUE_W];
      top_value <= ram_rdata[msk_pkg::VALUE_W-1:0];
    end else if (ram_we) begin
      top_min   <= push_min;
      top_value <= push_value;
    end
  end

  // Result registers.
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      result_value <= result_next;
      status       <= status_next;
      entries_held <= msk_pkg::HELD_W'(count_next);
    end
  end

endmodule

`default_nettype wire

@@ hw/rtl/min_tracking_stack_unit.sv @@
// Top level of the min-tracking stack: controller and datapath.
`default_nettype none

// A bounded LIFO of signed 32-bit values, msk_pkg::STACK_DEPTH entries deep, that also
// reports the exact minimum of its contents. Every command (push, pop, query minimum,
// peek top) gives one result item with a value, a status (ok, empty, or full with the
// push dropped) and the entry count after the command. The top entry and its running
// minimum are kept in registers, so push, query and peek need no RAM read; a pop that
// leaves entries on the stack adds a refill state that stalls input, since the entry
// beneath must be read back from the registered-read entry RAM. A new item is accepted
// while the previous result still waits in the output register, as long as that
// register is being drained. No clearing pass is needed after reset.
module min_tracking_stack_unit (
  input  wire logic                               clk,
  input  wire logic                               rst,
  input  wire logic                               in_valid,
  output logic                                    in_stall,
  input  wire logic [1:0]                         command,
  input  wire logic signed [msk_pkg::VALUE_W-1:0] push_value,
  output logic                                    out_valid,
  input  wire logic                               out_stall,
  output logic signed [msk_pkg::VALUE_W-1:0]      result_value,
  output logic [1:0]                              status,
  output logic [msk_pkg::HELD_W-1:0]              entries_held
);

  msk_pkg::ctrl_cmd_t  cmd;
  msk_pkg::dp_status_t dp_status;

  // Handshake and sequencing.
  msk_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .dp_status (dp_status),
    .cmd       (cmd)
  );

  // Storage and result computation.
  msk_datapath u_datapath (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .dp_status    (dp_status),
    .command      (command),
    .push_value   (push_value),
    .result_value (result_value),
    .status       (status),
    .entries_held (entries_held)
  );

endmodule

`default_nettype wire
